### design/sliding_window_p99_monitor_assert.svh
// Assertion macros for the frame time percentile monitor.
`ifndef SLIDING_WINDOW_P99_MONITOR_ASSERT_SVH
`define SLIDING_WINDOW_P99_MONITOR_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SWPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SWPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/swpm_pkg.sv
// Shared constants and types of the frame time percentile monitor.
package swpm_pkg;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned OUT_CNT_W = 9;
	localparam int unsigned MIN_SAMPLES = 100;
	localparam logic [VAL_W-1:0] BUDGET_RESET = 32'd16667;

	// floor(x / 100) as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x up to 1024
	localparam int unsigned DIV100_MUL = 5243;
	localparam int unsigned DIV100_SHIFT = 19;
	localparam int unsigned DIV100_MUL_W = 13;

	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_END = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_UPD  = 3'b010,
		ST_RES  = 3'b100
	} state_t;

	// Position flags a cell hands to its neighbors
	typedef struct packed {
		logic ins_before;
		logic del_before;
		logic del_here;
	} nbr_t;

endpackage

### design/swpm_if.sv
// Channel interfaces: frame events in, results out, budget register writes.
interface swpm_evt_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] timestamp_us;

	modport source (output valid, output operation, output timestamp_us, input ready);
	modport sink (input valid, input operation, input timestamp_us, output ready);
endinterface

interface swpm_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame_time_us;
	logic [31:0] p99_us;
	logic        p99_valid;
	logic        over_budget;
	logic [8:0]  sample_count;

	modport source (output valid, output frame_time_us, output p99_us, output p99_valid,
		output over_budget, output sample_count, input ready);
	modport sink (input valid, input frame_time_us, input p99_us, input p99_valid,
		input over_budget, input sample_count, output ready);
endinterface

interface swpm_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] budget_us;

	modport source (output valid, output budget_us, input ready);
	modport sink (input valid, input budget_us, output ready);
endinterface

### design/sliding_window_p99_monitor.sv
// Top level of the frame time 99th percentile monitor.
//
// Channels: evt takes frame events (operation 0 = begin, 1 = end, with a
// microsecond timestamp); res gives one result per end event that closes an
// open measurement; cfg writes the budget_us register, always ready.
// A begin event is taken and gives no result. An end event is
// taken, its sample written to the ring and the old ring entry read into a
// register; the sorted cell chain then shifts in the new sample and, once
// the window is full, drops the oldest; then the percentile is picked from
// the leading cells and compared to the budget into the result register.
// The next event is taken once the result register is loaded: the take
// with the registered ring read of the dropped entry, the chain shift and
// the result stage run in the states IDLE, UPD and RES in that order.
// The result register lets the next event in while a result waits; a
// further end event waits in its last step until res takes the previous one.
// Reset clears the chain, the count, the ring pointer, the measurement and
// the result; the budget returns to 16667 us. The ring needs no clearing:
// an entry's old value is used only once the ring has wrapped past it.
module sliding_window_p99_monitor
	import swpm_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 256
) (
	input logic        clk,
	input logic        arst_n,
	swpm_evt_if.sink   evt,
	swpm_res_if.source res,
	swpm_cfg_if.sink   cfg
);

	`include "sliding_window_p99_monitor_assert.svh"

	localparam int unsigned PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned TAP_N = WINDOW_DEPTH / 100 + 1;
	localparam int unsigned TAP_W = (TAP_N > 1) ? $clog2(TAP_N) : 1;
	localparam int unsigned PROD_W = CNT_W + DIV100_MUL_W;

	state_t           state_q;
	logic             meas_q;
	logic [VAL_W-1:0] start_q;
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] budget_q;
	logic [VAL_W-1:0] elapsed_s1;
	logic             del_en_s1;

	logic             res_valid_q;
	logic [VAL_W-1:0] res_frame_q;
	logic [VAL_W-1:0] res_p99_q;
	logic             res_p99_valid_q;
	logic             res_over_q;
	logic [CNT_W-1:0] res_count_q;

	logic             evt_take;
	logic             end_take;
	logic [VAL_W-1:0] elapsed;
	logic [VAL_W-1:0] old_val;
	logic [VAL_W-1:0] tap_val;
	logic [TAP_W-1:0] tap_idx;
	logic [PROD_W-1:0] tap_prod;
	logic [WINDOW_DEPTH-1:0] cell_vld;
	logic             full;
	logic             p99_ok;
	logic [VAL_W-1:0] p99;
	logic             res_load;

	assign evt.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign evt_take  = evt.valid && evt.ready;
	assign end_take  = evt_take && (evt.operation == OP_END) && meas_q;
	assign elapsed   = evt.timestamp_us - start_q;
	assign full      = (count_q == CNT_W'(WINDOW_DEPTH));

	swpm_ring #(
		.DEPTH(WINDOW_DEPTH),
		.PTR_W(PTR_W)
	) u_ring (
		.clk   (clk),
		.we    (end_take),
		.addr  (ptr_q),
		.wdata (elapsed),
		.rdata (old_val)
	);

	swpm_chain #(
		.DEPTH(WINDOW_DEPTH),
		.PTR_W(PTR_W),
		.TAP_N(TAP_N),
		.TAP_W(TAP_W)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (state_q == ST_UPD),
		.del_en   (del_en_s1),
		.new_val  (elapsed_s1),
		.del_val  (old_val),
		.slot     (ptr_q),
		.tap_idx  (tap_idx),
		.tap_val  (tap_val),
		.cell_vld (cell_vld)
	);

	// Rank from the top is floor(count / 100)
	assign tap_prod = PROD_W'(count_q) * PROD_W'(DIV100_MUL);
	assign tap_idx  = TAP_W'(tap_prod >> DIV100_SHIFT);
	assign p99_ok   = (count_q >= CNT_W'(MIN_SAMPLES));
	assign p99      = p99_ok ? tap_val : '0;
	assign res_load = (state_q == ST_RES) && (!res_valid_q || res.ready);

	// Sequence events and track measurement, pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			meas_q   <= 1'b0;
			start_q  <= '0;
			ptr_q    <= '0;
			count_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (evt_take && (evt.operation == OP_BEGIN)) begin
						meas_q  <= 1'b1;
						start_q <= evt.timestamp_us;
					end else if (end_take) begin
						meas_q  <= 1'b0;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					ptr_q   <= (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
					count_q <= full ? count_q : count_q + 1'b1;
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the new sample for the chain update
	always_ff @(posedge clk) begin
		if (end_take) begin
			elapsed_s1 <= elapsed;
			del_en_s1  <= full;
		end
	end

	// Budget register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (cfg.valid && cfg.ready) begin
			budget_q <= cfg.budget_us;
		end
	end

	// Result register: load on the last step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_frame_q     <= elapsed_s1;
			res_p99_q       <= p99;
			res_p99_valid_q <= p99_ok;
			res_over_q      <= p99_ok && (p99 > budget_q);
			res_count_q     <= count_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.frame_time_us = res_frame_q;
	assign res.p99_us        = res_p99_q;
	assign res.p99_valid     = res_p99_valid_q;
	assign res.over_budget   = res_over_q;
	assign res.sample_count  = OUT_CNT_W'(res_count_q);

	`SWPM_ASSERT_NOW(a_chain_count, clk, arst_n, 1'b1, $countones(cell_vld) == count_q, "fill off")
	`SWPM_ASSERT_NEXT(a_full_stays, clk, arst_n, (state_q == ST_UPD) && del_en_s1, full, "unfull")
	`SWPM_ASSERT_NEXT(a_end_disarms, clk, arst_n, end_take, !meas_q && (state_q == ST_UPD), "armed")
	`SWPM_ASSERT_NEXT(a_res_issued, clk, arst_n, res_load, res_valid_q && (state_q == ST_IDLE), "no res")

endmodule

### design/swpm_ring.sv
// Sample ring memory: one write port, one registered read port at the same address.
module swpm_ring
	import swpm_pkg::*;
#(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned PTR_W = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [PTR_W-1:0] addr,
	input  logic [VAL_W-1:0] wdata,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] ring_q [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	// Read the old entry while the new sample overwrites it
	always_ff @(posedge clk) begin
		if (we) begin
			ring_q[addr] <= wdata;
		end
		rdata_q <= ring_q[addr];
	end

	assign rdata = rdata_q;

endmodule

### design/swpm_cell.sv
// One cell of the sorted chain: holds one sample key, shifts to stay in descending order.
module swpm_cell
	import swpm_pkg::*;
#(
	parameter int unsigned KEY_W = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  logic             del_en,
	input  logic [KEY_W-1:0] new_key,
	input  logic [KEY_W-1:0] del_key,
	input  logic [KEY_W-1:0] lt_key,
	input  logic             lt_vld,
	input  nbr_t             lt_flg,
	input  logic [KEY_W-1:0] rt_key,
	input  logic             rt_vld,
	input  nbr_t             rt_flg,
	output logic [KEY_W-1:0] key,
	output logic             vld,
	output nbr_t             flg
);

	logic [KEY_W-1:0] key_q;
	logic             vld_q;
	logic [KEY_W-1:0] nxt_key;
	logic             nxt_vld;
	logic             hold;

	// Locate the new and the dropped sample relative to this cell
	always_comb begin
		flg.ins_before = !vld_q || (key_q < new_key);
		flg.del_before = del_en && vld_q && (key_q < del_key);
		flg.del_here   = del_en && vld_q && (key_q == del_key);
	end

	assign hold = (flg.ins_before == flg.del_before) && !flg.del_here;

	// Pick the entry that lands here: own, right neighbor, left neighbor or the new one
	always_comb begin
		priority if (hold) begin
			nxt_key = key_q;
			nxt_vld = vld_q;
		end else if (rt_flg.del_before && !rt_flg.ins_before) begin
			nxt_key = rt_key;
			nxt_vld = rt_vld;
		end else if (lt_flg.ins_before && !lt_flg.del_before && !lt_flg.del_here) begin
			nxt_key = lt_key;
			nxt_vld = lt_vld;
		end else begin
			nxt_key = new_key;
			nxt_vld = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (upd) begin
			vld_q <= nxt_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			key_q <= nxt_key;
		end
	end

	assign key = key_q;
	assign vld = vld_q;

endmodule

### design/swpm_chain.sv
// Row of sorted cells, largest first, with a read tap over the leading cells.
module swpm_chain
	import swpm_pkg::*;
#(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned PTR_W = 8,
	parameter int unsigned TAP_N = 3,
	parameter int unsigned TAP_W = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  logic             del_en,
	input  logic [VAL_W-1:0] new_val,
	input  logic [VAL_W-1:0] del_val,
	input  logic [PTR_W-1:0] slot,
	input  logic [TAP_W-1:0] tap_idx,
	output logic [VAL_W-1:0] tap_val,
	output logic [DEPTH-1:0] cell_vld
);

	localparam int unsigned KEY_W = VAL_W + PTR_W;

	logic [KEY_W-1:0] key_w [DEPTH];
	nbr_t             flg_w [DEPTH];
	logic [KEY_W-1:0] new_key;
	logic [KEY_W-1:0] del_key;

	// Break ties between equal samples by ring slot
	assign new_key = {new_val, slot};
	assign del_key = {del_val, slot};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] lt_key;
		logic             lt_vld;
		nbr_t             lt_flg;
		logic [KEY_W-1:0] rt_key;
		logic             rt_vld;
		nbr_t             rt_flg;

		if (i == 0) begin : g_first
			assign lt_key = '0;
			assign lt_vld = 1'b0;
			assign lt_flg = '0;
		end else begin : g_mid_l
			assign lt_key = key_w[i-1];
			assign lt_vld = cell_vld[i-1];
			assign lt_flg = flg_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rt_key = '0;
			assign rt_vld = 1'b0;
			assign rt_flg = '0;
		end else begin : g_mid_r
			assign rt_key = key_w[i+1];
			assign rt_vld = cell_vld[i+1];
			assign rt_flg = flg_w[i+1];
		end

		swpm_cell #(
			.KEY_W(KEY_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.upd     (upd),
			.del_en  (del_en),
			.new_key (new_key),
			.del_key (del_key),
			.lt_key  (lt_key),
			.lt_vld  (lt_vld),
			.lt_flg  (lt_flg),
			.rt_key  (rt_key),
			.rt_vld  (rt_vld),
			.rt_flg  (rt_flg),
			.key     (key_w[i]),
			.vld     (cell_vld[i]),
			.flg     (flg_w[i])
		);
	end

	// Select the requested entry among the largest few
	always_comb begin
		tap_val = '0;
		for (int i = 0; i < TAP_N; i++) begin
			if (tap_idx == TAP_W'(i)) begin
				tap_val = key_w[i][KEY_W-1 -: VAL_W];
			end
		end
	end

endmodule
